@@ sv/frdp_pkg.sv @@
// ----------------------------------------------------------------------------
// frdp_pkg
// Types and constants shared by the framed record deframer and pacer.
// ----------------------------------------------------------------------------
package frdp_pkg;

  // Frame layout
  localparam int HEADER_BYTES   = 8;
  localparam int FRAME_OVERHEAD = 12;
  localparam int PAD_BYTES      = FRAME_OVERHEAD - HEADER_BYTES;

  // Header byte positions
  localparam int LEN_HI_POS  = 0;
  localparam int LEN_LO_POS  = 1;
  localparam int TOD_HI_POS  = 5;
  localparam int TOD_MID_POS = 6;
  localparam int TOD_LO_POS  = 7;

  // Envelope byte positions within the content
  localparam int ENV_CAT_POS    = 0;
  localparam int ENV_LEN_HI_POS = 1;
  localparam int ENV_LEN_LO_POS = 2;
  localparam int ENV_MIN_LEN    = 3;

  // Time of day arithmetic, in centiseconds
  localparam logic [39:0] DAY_CS      = 40'd8640000;
  localparam logic [39:0] HALF_DAY_CS = 40'd4320000;
  localparam logic [39:0] MAX40       = {40{1'b1}};

  localparam logic [23:0] RATE_RESET = 24'd65536;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_DESC    = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_SHORT   = 2'd2,
    KIND_TRUNC   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PAD     = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CFG_USE_REFERENCE   = 2'd0,
    CFG_BASE_TOD        = 2'd1,
    CFG_RATE_RECIPROCAL = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } rec_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  content_byte;
    logic        last_of_frame;
    logic [15:0] body_len;
    logic [47:0] send_offset;
    logic        envelope_ok;
    logic [7:0]  category;
  } res_t;

  // Up to two results caused by one byte, plus the frame time of a descriptor
  typedef struct packed {
    logic [1:0]  cnt;
    res_t        r0;
    res_t        r1;
    logic [23:0] tod;
  } bundle_t;

endpackage

@@ sv/framed_record_deframer_pacer_core.sv @@
// ----------------------------------------------------------------------------
// framed_record_deframer_pacer_core
// Splits a recorded byte stream into frames and reports paced descriptors.
// ----------------------------------------------------------------------------
// The rec channel takes one byte of the recording per transaction, with
// stream_end set on the final byte. The res channel gives frame descriptors
// (content length and send offset), content bytes (the last one carrying the
// envelope check and category) and the two error kinds. Both channels move a
// transaction on a rising edge where valid is high and stall is low.
// A byte is taken in every cycle where rec_stall is low; its results pass
// through the stages below and the result queue before res_valid rises.
// The path is a parse stage, a time unroll stage, a subtract stage, a split
// 40x24 multiply stage and a combine stage that writes an eight-entry result
// queue. rec_stall rises only when the results already in flight could fill
// that queue, so a stalled receiver backs the block up and nothing is lost.
// Once halted by a short length, a truncated frame or the end of the stream,
// the block keeps taking bytes and discards them until reset.
// Reset (rst, synchronous) empties the pipeline and queue, returns the parser
// to the header and sets use_reference 0, base_tod 0 and
// rate_reciprocal 65536. Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module framed_record_deframer_pacer_core
  import frdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rec_valid,
  output logic        rec_stall,
  input  rec_t        rec,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CW = FIFO_AW + 2;

  // Configuration
  logic        use_reference;
  logic [23:0] base_tod;
  logic [23:0] rate_reciprocal;

  // Parser state
  phase_t      phase, phase_next;
  logic [15:0] byte_index, byte_index_next;
  logic [15:0] frame_len, frame_len_next;
  logic [23:0] frame_tod, frame_tod_next;
  logic [7:0]  env_category, env_category_next;
  logic [15:0] env_length, env_length_next;
  logic        halted, halted_next;

  // Time state
  logic        first_seen;
  logic [23:0] pacing_base;
  logic [39:0] prev_time;
  logic [39:0] day_offset;

  // Pipeline
  bundle_t     s1, s1_next;
  bundle_t     s2, s3, s4, s4_out;
  logic [39:0] s2_t;
  logic [23:0] s2_base;
  logic [39:0] s3_diff;
  logic [43:0] s4_pl, s4_ph;

  // Result queue
  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   fifo_count;
  logic [CW-1:0]      reserved;
  logic               pop;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      use_reference   <= 1'b0;
      base_tod        <= '0;
      rate_reciprocal <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_USE_REFERENCE:   use_reference   <= cfg_data[0];
        CFG_BASE_TOD:        base_tod        <= cfg_data;
        CFG_RATE_RECIPROCAL: rate_reciprocal <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Parse stage
  // --------------------------------------------------------------------------
  logic        take;
  logic [7:0]  b;
  logic        fin;
  logic [15:0] clen;
  logic        hdr_last, len_short, cont_last, pad_last;
  logic [23:0] tod_full;
  logic [7:0]  cat_eff;
  logic [15:0] envlen_eff;
  logic        env_ok;

  assign take      = rec_valid && !rec_stall && !halted;
  assign b         = rec.data_byte;
  assign fin       = rec.stream_end;
  assign clen      = frame_len - 16'(FRAME_OVERHEAD);
  assign hdr_last  = (byte_index == 16'(HEADER_BYTES - 1));
  assign len_short = (frame_len < 16'(FRAME_OVERHEAD));
  assign cont_last = ({1'b0, byte_index} + 17'd1) >= {1'b0, clen};
  assign pad_last  = ({1'b0, byte_index} + 17'd1) >= 17'(PAD_BYTES);
  assign tod_full  = {frame_tod[23:8], b};

  // The envelope fields as they stand after this byte has been taken
  assign cat_eff    = (byte_index == 16'(ENV_CAT_POS)) ? b : env_category;
  assign envlen_eff = (byte_index == 16'(ENV_LEN_HI_POS)) ? {b, 8'h00} :
                      (byte_index == 16'(ENV_LEN_LO_POS)) ? {env_length[15:8], b} :
                      env_length;
  assign env_ok = (clen >= 16'(ENV_MIN_LEN)) && (cat_eff != 8'h00) &&
                  (envlen_eff >= 16'(ENV_MIN_LEN)) && (envlen_eff <= clen);

  // Next state
  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    frame_len_next    = frame_len;
    frame_tod_next    = frame_tod;
    env_category_next = env_category;
    env_length_next   = env_length;
    halted_next       = halted;
    if (take) begin
      // Every phase stops at the end of the stream.
      if (fin) begin
        halted_next = 1'b1;
      end
      unique case (phase)
        PH_HEADER: begin
          unique case (byte_index)
            16'(LEN_HI_POS):  frame_len_next = {b, 8'h00};
            16'(LEN_LO_POS):  frame_len_next = {frame_len[15:8], b};
            16'(TOD_HI_POS):  frame_tod_next = {b, 16'h0000};
            16'(TOD_MID_POS): frame_tod_next = {frame_tod[23:16], b, 8'h00};
            16'(TOD_LO_POS):  frame_tod_next = tod_full;
            default: ;
          endcase
          if (hdr_last) begin
            byte_index_next = '0;
            if (len_short) begin
              halted_next = 1'b1;
            end else begin
              env_category_next = '0;
              env_length_next   = '0;
              phase_next        = (clen == 16'd0) ? PH_PAD : PH_CONTENT;
            end
          end else begin
            byte_index_next = byte_index + 16'd1;
          end
        end
        PH_CONTENT: begin
          env_category_next = cat_eff;
          env_length_next   = envlen_eff;
          if (cont_last) begin
            phase_next      = PH_PAD;
            byte_index_next = '0;
          end else begin
            byte_index_next = byte_index + 16'd1;
          end
        end
        default: begin
          if (pad_last) begin
            phase_next      = PH_HEADER;
            byte_index_next = '0;
          end else begin
            byte_index_next = byte_index + 16'd1;
          end
        end
      endcase
    end
  end

  // Results of this byte
  always_comb begin
    s1_next          = '0;
    s1_next.r0.kind  = KIND_DESC;
    s1_next.r1.kind  = KIND_TRUNC;
    if (take) begin
      unique case (phase)
        PH_HEADER: begin
          if (!hdr_last) begin
            if (fin) begin
              s1_next.cnt     = 2'd1;
              s1_next.r0.kind = KIND_TRUNC;
            end
          end else if (len_short) begin
            s1_next.cnt     = 2'd1;
            s1_next.r0.kind = KIND_SHORT;
          end else begin
            s1_next.r0.kind     = KIND_DESC;
            s1_next.r0.body_len = clen;
            s1_next.tod         = tod_full;
            // A header with content to follow cannot end the stream cleanly.
            s1_next.cnt = (fin && clen != 16'd0) ? 2'd2 : 2'd1;
          end
        end
        PH_CONTENT: begin
          s1_next.r0.kind         = KIND_CONTENT;
          s1_next.r0.content_byte = b;
          if (cont_last) begin
            s1_next.cnt              = 2'd1;
            s1_next.r0.last_of_frame = 1'b1;
            s1_next.r0.envelope_ok   = env_ok;
            s1_next.r0.category      = cat_eff;
          end else begin
            s1_next.cnt = fin ? 2'd2 : 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_index   <= '0;
      frame_len    <= '0;
      frame_tod    <= '0;
      env_category <= '0;
      env_length   <= '0;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      frame_len    <= frame_len_next;
      frame_tod    <= frame_tod_next;
      env_category <= env_category_next;
      env_length   <= env_length_next;
      halted       <= halted_next;
    end
  end

  // --------------------------------------------------------------------------
  // Time unroll stage: midnight crossings and the pacing base
  // --------------------------------------------------------------------------
  logic        s1_desc, first;
  logic [39:0] prev_eff;
  logic [23:0] base_eff;
  logic [40:0] t0, dd;
  logic [41:0] t0h, t0d;
  logic        wrap, d_ovf;
  logic [39:0] off_new, t_new;

  assign s1_desc  = (s1.cnt != 2'd0) && (s1.r0.kind == KIND_DESC);
  assign first    = !first_seen;
  assign prev_eff = first ? {16'h0000, s1.tod} : prev_time;
  assign base_eff = first ? (use_reference ? base_tod : s1.tod) : pacing_base;

  // The candidate sums are formed side by side and only selected afterwards.
  assign t0    = {1'b0, day_offset} + {17'h0, s1.tod};
  assign t0h   = {2'b00, day_offset} + {18'h0, s1.tod} + {2'b00, HALF_DAY_CS};
  assign t0d   = {2'b00, day_offset} + {18'h0, s1.tod} + {2'b00, DAY_CS};
  assign dd    = {1'b0, day_offset} + {1'b0, DAY_CS};
  assign d_ovf = dd[40];
  assign wrap  = t0h < {2'b00, prev_eff};

  always_comb begin
    if (!wrap) begin
      off_new = day_offset;
      t_new   = t0[40] ? MAX40 : t0[39:0];
    end else if (d_ovf) begin
      off_new = MAX40;
      t_new   = MAX40;
    end else begin
      off_new = dd[39:0];
      t_new   = (t0d[41:40] != 2'b00) ? MAX40 : t0d[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen  <= 1'b0;
      pacing_base <= '0;
      prev_time   <= '0;
      day_offset  <= '0;
    end else if (s1_desc) begin
      first_seen  <= 1'b1;
      pacing_base <= base_eff;
      prev_time   <= t_new;
      day_offset  <= off_new;
    end
  end

  // --------------------------------------------------------------------------
  // Subtract, multiply and combine stages
  // --------------------------------------------------------------------------
  logic [39:0] diff;
  logic [63:0] product;

  assign diff    = (s2_t > {16'h0000, s2_base}) ? (s2_t - {16'h0000, s2_base}) : '0;
  assign product = {s4_ph, 20'h00000} + {20'h00000, s4_pl};

  always_comb begin
    s4_out = s4;
    if (s4.r0.kind == KIND_DESC) begin
      s4_out.r0.send_offset = product[63:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.cnt <= '0;
      s2.cnt <= '0;
      s3.cnt <= '0;
      s4.cnt <= '0;
    end else begin
      s1 <= s1_next;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
    end
  end

  always_ff @(posedge clk) begin
    s2_t    <= t_new;
    s2_base <= base_eff;
    s3_diff <= diff;
    s4_pl   <= s3_diff[19:0] * rate_reciprocal;
    s4_ph   <= s3_diff[39:20] * rate_reciprocal;
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  assign pop       = res_valid && !res_stall;
  assign res_valid = (fifo_count != '0);
  assign res       = fifo_mem[rd_ptr];

  // Room is kept for everything still in the pipeline plus two more results.
  assign reserved = CW'(fifo_count) + CW'(s1.cnt) + CW'(s2.cnt) + CW'(s3.cnt) +
                    CW'(s4.cnt);
  assign rec_stall = reserved > CW'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (s4.cnt != 2'd0) begin
      fifo_mem[wr_ptr] <= s4_out.r0;
    end
    if (s4.cnt == 2'd2) begin
      fifo_mem[FIFO_AW'(wr_ptr + 1'b1)] <= s4_out.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_AW'(s4.cnt);
      rd_ptr     <= rd_ptr + FIFO_AW'(pop);
      fifo_count <= fifo_count + (FIFO_AW + 1)'(s4.cnt) - (FIFO_AW + 1)'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_reserved_fits: assert property (@(posedge clk) disable iff (rst)
    reserved <= CW'(FIFO_DEPTH))
    else $error("results in flight exceed the result queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |=> (s1.cnt == 2'd0))
    else $error("result produced after the block halted");

  a_second_is_trunc: assert property (@(posedge clk) disable iff (rst)
    (s1.cnt == 2'd2) |-> (s1.r1.kind == KIND_TRUNC) && $past(rec.stream_end))
    else $error("second result of a byte is not a truncation at stream end");

endmodule

@@ dv/framed_record_deframer_pacer_core_tb.sv @@
// ----------------------------------------------------------------------------
// framed_record_deframer_pacer_core_tb
// Self-checking testbench for the framed record deframer and pacer. It feeds
// a single recording as framed bytes: two fixed frames at the day's edges,
// then random frames in phases with register rewrites in between. The run
// closes with one randomly chosen ending: a cut-short frame, a too-short
// length, a broken header or a clean end. A scoreboard predicts every
// result and compares it field by field, with random gaps and stalls on
// both channels.
// ----------------------------------------------------------------------------
module framed_record_deframer_pacer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frdp_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_TARGET   = 1150;
  localparam int LONG_HOLD     = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rec_valid = 1'b0;
  logic        rec_stall;
  rec_t        rec = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_USE_REFERENCE;
  logic [23:0] cfg_data = '0;

  int cycle_count = 0;
  int sent_bytes = 0;
  bit steady = 1'b0;
  bit hold_request = 1'b0;

  // Tracks the frame parser and the pacing clock, and holds the results
  // still owed by the block in arrival order.
  class deframe_scoreboard;
    logic        use_ref;
    logic [23:0] ref_time;
    logic [23:0] rate_recip;
    phase_t      phase;
    logic [15:0] pos;
    logic [15:0] flen;
    logic [23:0] ftod;
    bit          first_seen;
    logic [23:0] base;
    logic [39:0] prev_t;
    logic [39:0] day_off;
    logic [7:0]  env_cat;
    logic [15:0] env_len;
    bit          halted;
    res_t        due[$];
    int          errors;

    function new();
      use_ref    = 1'b0;
      ref_time   = '0;
      rate_recip = RATE_RESET;
      phase      = PH_HEADER;
      pos        = '0;
      flen       = '0;
      ftod       = '0;
      first_seen = 1'b0;
      base       = '0;
      prev_t     = '0;
      day_off    = '0;
      env_cat    = '0;
      env_len    = '0;
      halted     = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [23:0] val);
      case (idx)
        CFG_USE_REFERENCE:   use_ref = val[0];
        CFG_BASE_TOD:        ref_time = val;
        CFG_RATE_RECIPROCAL: rate_recip = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void queue_result(kind_t k, logic [7:0] cb, logic lst, logic [15:0] cl,
                               logic [47:0] off, logic ok, logic [7:0] cat);
      res_t r;
      r.kind          = k;
      r.content_byte  = cb;
      r.last_of_frame = lst;
      r.body_len      = cl;
      r.send_offset   = off;
      r.envelope_ok   = ok;
      r.category      = cat;
      due.push_back(r);
    endfunction

    function logic [39:0] sat40(logic [63:0] v);
      return (v > 64'(MAX40)) ? MAX40 : v[39:0];
    endfunction

    function void take_byte(rec_t item);
      logic [7:0]  b;
      logic [15:0] clen;
      logic [63:0] t;
      logic [63:0] diff;
      logic [63:0] prod;
      bit          ok;
      b = item.data_byte;
      if (halted) return;
      case (phase)
        PH_HEADER: begin
          case (pos)
            LEN_HI_POS:  flen = {b, 8'h00};
            LEN_LO_POS:  flen[7:0] = b;
            TOD_HI_POS:  ftod = {b, 16'h0000};
            TOD_MID_POS: ftod[15:8] = b;
            TOD_LO_POS:  ftod[7:0] = b;
            default: ;
          endcase
          pos++;
          if (pos < HEADER_BYTES) begin
            if (item.stream_end) begin
              queue_result(KIND_TRUNC, '0, 1'b0, '0, '0, 1'b0, '0);
              halted = 1'b1;
            end
            return;
          end
          pos = '0;
          if (flen < FRAME_OVERHEAD) begin
            queue_result(KIND_SHORT, '0, 1'b0, '0, '0, 1'b0, '0);
            halted = 1'b1;
            return;
          end
          if (!first_seen) begin
            first_seen = 1'b1;
            base       = use_ref ? ref_time : ftod;
            prev_t     = 40'(ftod);
          end
          // A fall of more than half a day means the recording crossed midnight.
          if (64'(ftod) + 64'(day_off) + 64'(HALF_DAY_CS) < 64'(prev_t))
            day_off = sat40(64'(day_off) + 64'(DAY_CS));
          t      = 64'(sat40(64'(ftod) + 64'(day_off)));
          prev_t = t[39:0];
          diff   = (t > 64'(base)) ? t - 64'(base) : 64'd0;
          prod   = diff * 64'(rate_recip);
          queue_result(KIND_DESC, '0, 1'b0, 16'(flen - FRAME_OVERHEAD), prod[63:16], 1'b0, '0);
          env_cat = '0;
          env_len = '0;
          phase   = (flen == FRAME_OVERHEAD) ? PH_PAD : PH_CONTENT;
          if (item.stream_end) begin
            if (phase == PH_CONTENT) queue_result(KIND_TRUNC, '0, 1'b0, '0, '0, 1'b0, '0);
            halted = 1'b1;
          end
        end
        PH_CONTENT: begin
          clen = 16'(flen - FRAME_OVERHEAD);
          if (pos == ENV_CAT_POS) env_cat = b;
          else if (pos == ENV_LEN_HI_POS) env_len = {b, 8'h00};
          else if (pos == ENV_LEN_LO_POS) env_len[7:0] = b;
          if (32'(pos) + 1 >= 32'(clen)) begin
            ok = (clen >= ENV_MIN_LEN) && (env_cat != 8'h00) &&
                 (env_len >= ENV_MIN_LEN) && (env_len <= clen);
            queue_result(KIND_CONTENT, b, 1'b1, '0, '0, ok, env_cat);
            phase = PH_PAD;
            pos   = '0;
            if (item.stream_end) halted = 1'b1;
          end else begin
            queue_result(KIND_CONTENT, b, 1'b0, '0, '0, 1'b0, '0);
            pos++;
            if (item.stream_end) begin
              queue_result(KIND_TRUNC, '0, 1'b0, '0, '0, 1'b0, '0);
              halted = 1'b1;
            end
          end
        end
        default: begin
          // Padding is dropped; an end of stream here is a clean end.
          pos++;
          if (pos >= PAD_BYTES) begin
            phase = PH_HEADER;
            pos   = '0;
          end
          if (item.stream_end) halted = 1'b1;
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    function string field_msg(string name, logic [63:0] got, logic [63:0] want);
      return $sformatf("%s got 0x%0h, expected 0x%0h", name, got, want);
    endfunction

    task check_result(res_t got);
      res_t want;
      if (due.size() == 0) begin
        report($sformatf("result of kind %0d with nothing expected", got.kind));
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind) report(field_msg("kind", got.kind, want.kind));
      if (got.content_byte !== want.content_byte)
        report(field_msg("content_byte", got.content_byte, want.content_byte));
      if (got.last_of_frame !== want.last_of_frame)
        report(field_msg("last_of_frame", got.last_of_frame, want.last_of_frame));
      if (got.body_len !== want.body_len)
        report(field_msg("body_len", got.body_len, want.body_len));
      if (got.send_offset !== want.send_offset)
        report(field_msg("send_offset", got.send_offset, want.send_offset));
      if (got.envelope_ok !== want.envelope_ok)
        report(field_msg("envelope_ok", got.envelope_ok, want.envelope_ok));
      if (got.category !== want.category)
        report(field_msg("category", got.category, want.category));
    endtask
  endclass

  deframe_scoreboard board;

  framed_record_deframer_pacer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  function automatic logic [23:0] pick_ref();
    case ($urandom_range(0, 2))
      0:       return 24'd0;
      1:       return 24'd8639999;
      default: return 24'($urandom_range(0, 8639999));
    endcase
  endfunction

  function automatic logic [23:0] pick_rate();
    case ($urandom_range(0, 3))
      0:       return 24'd1;
      1:       return 24'hFFFFFF;
      2:       return RATE_RESET;
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [7:0] pick_cat();
    return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [15:0] pick_env(int clen);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(ENV_MIN_LEN, (clen > ENV_MIN_LEN) ? clen : ENV_MIN_LEN));
    if (r < 85) return 16'($urandom_range(0, ENV_MIN_LEN - 1));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!steady && $urandom_range(0, 99) >= 70) begin
      rec_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    rec_valid <= 1'b1;
    rec <= '{data_byte: b, stream_end: fin};
    @(posedge clk);
    while (rec_stall) @(posedge clk);
    board.take_byte(rec);
    sent_bytes++;
  endtask

  // Sends one frame; the byte at index cut carries stream_end and is the last sent.
  task automatic send_frame(input logic [15:0] flen, input logic [23:0] tod,
                            input logic [7:0] cat, input logic [15:0] envl, input int cut);
    int total;
    logic [7:0] b;
    total = (flen < FRAME_OVERHEAD) ? HEADER_BYTES : int'(flen);
    for (int i = 0; i < total; i++) begin
      case (i)
        LEN_HI_POS:                    b = flen[15:8];
        LEN_LO_POS:                    b = flen[7:0];
        TOD_HI_POS:                    b = tod[23:16];
        TOD_MID_POS:                   b = tod[15:8];
        TOD_LO_POS:                    b = tod[7:0];
        HEADER_BYTES + ENV_CAT_POS:    b = cat;
        HEADER_BYTES + ENV_LEN_HI_POS: b = envl[15:8];
        HEADER_BYTES + ENV_LEN_LO_POS: b = envl[7:0];
        default:                       b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == cut);
      if (i == cut) break;
    end
  endtask

  task automatic write_config(input logic ur, input logic [23:0] rt, input logic [23:0] rr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_USE_REFERENCE;
    cfg_data  <= {23'd0, ur};
    @(posedge clk);
    board.set_reg(CFG_USE_REFERENCE, {23'd0, ur});
    cfg_index <= CFG_BASE_TOD;
    cfg_data  <= rt;
    @(posedge clk);
    board.set_reg(CFG_BASE_TOD, rt);
    cfg_index <= CFG_RATE_RECIPROCAL;
    cfg_data  <= rr;
    @(posedge clk);
    board.set_reg(CFG_RATE_RECIPROCAL, rr);
    cfg_we <= 1'b0;
  endtask

  // Padding bytes give no result, so a settling wait lets them clear the pipe.
  task automatic wait_idle();
    rec_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) board.check_result(res);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (steady || $urandom_range(0, 99) < 65) begin
        res_stall <= 1'b0;
      end else begin
        stall_left = idle_len() - 1;
        res_stall <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int tod;
    int clen;
    int r;
    int phase_no;
    int w;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Half of the runs pace the first frame with the reset register values.
    if ($urandom_range(0, 1) == 1) write_config(1'($urandom_range(0, 1)), pick_ref(), pick_rate());

    // An empty frame at the last centisecond of the day, then a frame just
    // after midnight whose envelope is the smallest well-formed one.
    send_frame(16'(FRAME_OVERHEAD), 24'd8639999, 8'h00, 16'h0000, -1);
    send_frame(16'(FRAME_OVERHEAD + 3), 24'd0, 8'hFF, 16'h0003, -1);

    tod      = 0;
    phase_no = 0;
    while (sent_bytes < ITEM_TARGET) begin
      wait_idle();
      write_config(1'($urandom_range(0, 1)), pick_ref(), pick_rate());
      steady = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        // The receiver holds off while frames keep coming, so the block backs up.
        steady       = 1'b1;
        hold_request = 1'b1;
      end
      repeat ($urandom_range(3, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 80) tod = (tod + $urandom_range(0, 3000)) % 8640000;
        else if (r < 90) tod = (tod >= 1000) ? tod - $urandom_range(0, 1000) : tod;
        else if (r < 95) tod = 8640000 - $urandom_range(1, 500);
        else tod = $urandom_range(0, 24'hFFFFFF);
        r = $urandom_range(0, 99);
        if (r < 70) clen = $urandom_range(0, 8);
        else if (r < 95) clen = $urandom_range(9, 40);
        else clen = $urandom_range(41, 120);
        send_frame(16'(FRAME_OVERHEAD + clen), 24'(tod), pick_cat(), pick_env(clen), -1);
      end
      phase_no++;
    end
    steady = 1'b0;

    // The recording ends one way or another; everything after is discarded.
    clen = $urandom_range(0, 6);
    case ($urandom_range(0, 3))
      0: send_frame(16'hFFFF, 24'(tod), pick_cat(), pick_env(65523), $urandom_range(7, 12));
      1: send_frame(16'($urandom_range(0, FRAME_OVERHEAD - 1)), 24'(tod), 8'h00, 16'h0000, -1);
      2: send_frame(16'(FRAME_OVERHEAD + clen), 24'(tod), pick_cat(), pick_env(clen),
                    $urandom_range(0, HEADER_BYTES - 2));
      default: send_frame(16'(FRAME_OVERHEAD + clen), 24'(tod), pick_cat(), pick_env(clen),
                          $urandom_range(HEADER_BYTES - 1 + clen, FRAME_OVERHEAD - 1 + clen));
    endcase
    repeat (5) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    rec_valid <= 1'b0;

    for (w = 0; w < 20000 && board.pending() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d expected results never arrived", board.pending()));

    if (board.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
sv/frdp_pkg.sv
sv/framed_record_deframer_pacer_core.sv
dv/framed_record_deframer_pacer_core_tb.sv
